// File: hdl/esmv_pkg.sv
// Shared types and constants for the ELLPACK sparse matrix-vector block.
// No dependencies; every other file imports this package.
`default_nettype none

package esmv_pkg;

    localparam int VECTOR_DEPTH  = 1024;
    localparam int MAX_ROW_WIDTH = 64;

    localparam int INDEX_W = $clog2(VECTOR_DEPTH);
    localparam int VALUE_W = 32;
    localparam int ROW_W   = 16;
    localparam int WIDTH_W = 7;
    localparam int SLOT_W  = $clog2(MAX_ROW_WIDTH + 1);
    localparam int ACC_W   = 64;
    localparam int SUM_W   = 48;
    localparam int FRAC_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [0:0] {
        ACT_VEC_WRITE = 1'b0,
        ACT_ENTRY     = 1'b1
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_WIDTH = 2'd0,
        REG_ROW_COUNT = 2'd1
    } cfg_reg_t;

    // Per-entry control travelling down the pipeline beside the data
    typedef struct packed {
        logic             last;
        logic [ROW_W-1:0] row;
    } entry_tag_t;

endpackage

`default_nettype wire

// File: hdl/esmv_ifs.sv
// Valid/ready channel interfaces: input requests, results, register writes.
// Depends on esmv_pkg for field widths.
`default_nettype none

interface esmv_item_if
    import esmv_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output action, output index, output value, input ready);
    modport sink   (input valid, input action, input index, input value, output ready);
endinterface

interface esmv_result_if
    import esmv_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [ROW_W-1:0]        row_index;
    logic signed [SUM_W-1:0] row_sum;
    logic                    saturated;

    modport source (output valid, output row_index, output row_sum, output saturated,
                    input ready);
    modport sink   (input valid, input row_index, input row_sum, input saturated,
                    output ready);
endinterface

interface esmv_cfg_if
    import esmv_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/esmv_vec_mem.sv
// Vector store: single-port synchronous RAM, one access per cycle while enabled; a write also reads the old word.
// Depends on esmv_pkg for depth and widths.
`default_nettype none

module esmv_vec_mem
    import esmv_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic                      wr,
    input  wire logic [INDEX_W-1:0]        addr,
    input  wire logic signed [VALUE_W-1:0] wdata,
    output logic signed [VALUE_W-1:0]      rdata
);

    logic signed [VALUE_W-1:0] mem [VECTOR_DEPTH];

    // Read data holds while the pipeline stage after it is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (wr)
                mem[addr] <= wdata;
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/esmv_seq.sv
// Configuration registers and slot/row counters; tags each matrix entry.
// Depends on esmv_pkg and esmv_cfg_if.
`default_nettype none

module esmv_seq
    import esmv_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    esmv_cfg_if.sink    cfg,
    input  wire logic   entry_fire,
    output entry_tag_t  tag
);

    logic [WIDTH_W-1:0] row_width_reg;
    logic [ROW_W-1:0]   row_count_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [SLOT_W-1:0]  eff_width;
    logic [SLOT_W-1:0]  slot_inc;
    logic [ROW_W:0]     row_inc;
    logic               last;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (row_width_reg == '0)
            eff_width = SLOT_W'(1);
        else if (32'(row_width_reg) > MAX_ROW_WIDTH)
            eff_width = SLOT_W'(MAX_ROW_WIDTH);
        else
            eff_width = SLOT_W'(row_width_reg);
    end

    assign slot_inc = slot_reg + SLOT_W'(1);
    assign last     = (slot_inc >= eff_width);
    assign row_inc  = {1'b0, row_reg} + (ROW_W+1)'(1);

    always_comb
    begin
        slot_next = slot_reg;
        row_next  = row_reg;
        if (entry_fire)
        begin
            if (last)
            begin
                slot_next = '0;
                // Wrap after the last row; a zero row count wraps at the full range
                if (row_count_reg != '0 && row_inc >= {1'b0, row_count_reg})
                    row_next = '0;
                else
                    row_next = row_inc[ROW_W-1:0];
            end
            else
                slot_next = slot_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= WIDTH_W'(1);
            row_count_reg <= ROW_W'(1);
            slot_reg      <= '0;
            row_reg       <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            row_reg  <= row_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_ROW_WIDTH: row_width_reg <= cfg.data[WIDTH_W-1:0];
                    REG_ROW_COUNT: row_count_reg <= cfg.data[ROW_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign tag.last = last;
    assign tag.row  = row_reg;

endmodule

`default_nettype wire

// File: hdl/esmv_mac.sv
// Multiply-accumulate pipeline: product, Q.16 accumulate, saturate, output register.
// Depends on esmv_pkg and esmv_result_if; read data comes from esmv_vec_mem.
`default_nettype none

module esmv_mac
    import esmv_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic signed [VALUE_W-1:0] in_value,
    input  wire entry_tag_t                in_tag,
    input  wire logic signed [VALUE_W-1:0] rd_data,
    output logic                           in_ready,
    esmv_result_if.source                  res
);

    logic                      v1_reg;
    logic signed [VALUE_W-1:0] val1_reg;
    entry_tag_t                tag1_reg;
    logic                      v2_reg;
    logic signed [ACC_W-1:0]   prod2_reg;
    entry_tag_t                tag2_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      v3_reg;
    logic signed [ACC_W-1:0]   sum3_reg;
    logic [ROW_W-1:0]          row3_reg;
    logic                      vo_reg;
    logic [ROW_W-1:0]          row_o_reg;
    logic signed [SUM_W-1:0]   sum_o_reg;
    logic                      sat_o_reg;

    logic                      en1;
    logic                      en2;
    logic                      en3;
    logic                      en_o;
    logic signed [ACC_W-1:0]   prod;
    logic signed [ACC_W-1:0]   acc_sum;
    logic [ACC_W-SUM_W:0]      sum_hi;
    logic                      sat;
    logic signed [SUM_W-1:0]   clipped;

    // Stages collapse bubbles; non-final entries leave at the accumulator
    assign en_o = !vo_reg || res.ready;
    assign en3  = !v3_reg || en_o;
    assign en2  = !v2_reg || !tag2_reg.last || en3;
    assign en1  = !v1_reg || en2;
    assign in_ready = en1;

    assign prod    = val1_reg * rd_data;
    assign acc_sum = acc_reg + (prod2_reg >>> FRAC_W);

    assign sum_hi  = sum3_reg[ACC_W-1:SUM_W-1];
    assign sat     = !((&sum_hi) || !(|sum_hi));
    assign clipped = sat ? (sum3_reg[ACC_W-1] ? SUM_MIN : SUM_MAX) : sum3_reg[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            vo_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg && tag2_reg.last;
            if (en_o)
                vo_reg <= v3_reg;
            if (v2_reg && en2)
                acc_reg <= tag2_reg.last ? '0 : acc_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            val1_reg <= in_value;
            tag1_reg <= in_tag;
        end
        if (en2)
        begin
            prod2_reg <= prod;
            tag2_reg  <= tag1_reg;
        end
        if (en3)
        begin
            sum3_reg <= acc_sum;
            row3_reg <= tag2_reg.row;
        end
        if (en_o)
        begin
            row_o_reg <= row3_reg;
            sum_o_reg <= clipped;
            sat_o_reg <= sat;
        end
    end

    assign res.valid     = vo_reg;
    assign res.row_index = row_o_reg;
    assign res.row_sum   = sum_o_reg;
    assign res.saturated = sat_o_reg;

endmodule

`default_nettype wire

// File: hdl/ell_sparse_matvec.sv
// ELLPACK sparse matrix times dense vector in Q16.16, top level.
// Instantiates esmv_seq, esmv_vec_mem and esmv_mac; uses esmv_pkg and esmv_ifs.
//
// Write the vector with action 0 requests, then stream matrix entries (action 1)
// in row order, row_width entries per row. When ready, one request is taken every
// cycle, vector write or matrix entry alike, limited by the single port of the
// vector RAM. A row's result is registered after its last entry is accepted and
// stays in the output register until taken; vector writes and entries that do not
// end a row keep flowing behind a waiting result, and input ready drops once two
// more finished rows and one further matrix entry are queued behind it. Register
// writes are always taken at once and must only happen while the block is idle.
`default_nettype none

module ell_sparse_matvec
    import esmv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    esmv_cfg_if.sink      cfg,
    esmv_item_if.sink     item,
    esmv_result_if.source result
);

    logic       ready;
    logic       fire;
    logic       entry_fire;
    logic       vec_write;
    entry_tag_t tag;
    logic signed [VALUE_W-1:0] rd_data;

    assign item.ready = ready;
    assign fire       = item.valid && ready;
    assign entry_fire = fire && (item.action == ACT_ENTRY);
    assign vec_write  = fire && (item.action == ACT_VEC_WRITE);

    esmv_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .entry_fire (entry_fire),
        .tag        (tag)
    );

    esmv_vec_mem u_mem (
        .clk   (clk),
        .en    (ready),
        .wr    (vec_write),
        .addr  (item.index),
        .wdata (item.value),
        .rdata (rd_data)
    );

    esmv_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (entry_fire),
        .in_value (item.value),
        .in_tag   (tag),
        .rd_data  (rd_data),
        .in_ready (ready),
        .res      (result)
    );

    // Input stalls only when a finished result is held up at the output
    a_stall_needs_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        !ready |-> (result.valid && !result.ready))
        else $error("input stalled without a waiting result");

    // A clipped sum sits at one end of the 48-bit range
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.saturated) |->
            (result.row_sum == SUM_MAX || result.row_sum == SUM_MIN))
        else $error("saturated row sum not at a limit");

endmodule

`default_nettype wire
